/* hw/rtl/linear_ramp_generator_core_macros.svh */
// Assertion macros for the linear ramp generator core.
`ifndef LINEAR_RAMP_GENERATOR_CORE_MACROS_SVH
`define LINEAR_RAMP_GENERATOR_CORE_MACROS_SVH

`ifndef SYNTH
// Property must hold on every clock edge out of reset.
`define LRG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Condition must never be seen out of reset.
`define LRG_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define LRG_ASSERT(lbl, prop, msg)
`define LRG_ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

/* hw/rtl/lrg_pkg.sv */
// Types and constants for the linear ramp generator core.
package lrg_pkg;

  localparam int VALUE_W   = 16;  // target and reported value width
  localparam int ACC_W     = 32;  // scaled accumulator, step and count width
  localparam int REG_W     = 16;  // configuration register width
  localparam int CFG_IDX_W = 2;
  localparam int DIV_W     = 48;  // dividend width of the shared divider
  localparam int DIV_CNT_W = 6;

  localparam logic [DIV_CNT_W-1:0] DIV_SHORT = DIV_CNT_W'(ACC_W);
  localparam logic [DIV_CNT_W-1:0] DIV_LONG  = DIV_CNT_W'(DIV_W);

  localparam logic [REG_W-1:0] SCALE_RST = 16'd1;
  localparam logic [REG_W-1:0] FREQ_RST  = 16'd1000;

  localparam logic [CFG_IDX_W-1:0] CFG_SCALE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FREQ  = 2'd1;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_START = 2'd1,
    CMD_STOP  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_STEP_DIV = 8'b0000_0010,
    S_CUR_DIV  = 8'b0000_0100,
    S_DIFF     = 8'b0000_1000,
    S_CNT_MUL  = 8'b0001_0000,
    S_CNT_DIV  = 8'b0010_0000,
    S_OUT_LD   = 8'b0100_0000,
    S_OUT_DIV  = 8'b1000_0000
  } state_t;

endpackage

/* hw/rtl/linear_ramp_generator_core.sv */
// Linear setpoint ramp generator: sequencer, shared multiplier and radix-2 divider.
//
// Input channel (in_valid / in_stall): one command item, tick, start or stop,
// with a target and a slope that start uses. Result channel (out_valid /
// out_stall): one item per command, the reference in output units and a done
// flag. Configuration: cfg_write_en with cfg_index 0 (scaling factor) or
// 1 (tick frequency); write only while the block is idle.
// One item is in work at a time; in_stall is high until its result is loaded
// into the output register. All divisions run on one restoring divider, one
// quotient bit per cycle: tick, stop or unused command run the output division,
// start with a jump the step and output divisions, start with a ramp the step,
// current value, step count and output divisions of 32, 32, 48 and 32 bits. A
// stalled result stays in the output register while the next item is accepted
// and worked; the final load waits for the register to free up.
// Reset (rst_n low, synchronous) clears the reference, the ramp state and the
// output valid flag and loads scaling factor 1 and tick frequency 1000.
module linear_ramp_generator_core
  import lrg_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_write_en,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [REG_W-1:0]            cfg_wdata,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  in_command,
  input  logic signed [VALUE_W-1:0]   in_target_value,
  input  logic [15:0]                 in_slope_per_second,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [VALUE_W-1:0]   out_current_value,
  output logic                        out_ramp_done
);

`include "linear_ramp_generator_core_macros.svh"

  state_t state_r, state_nxt;

  logic [REG_W-1:0] scale_r, freq_r;
  logic [REG_W-1:0] scale_eff, freq_eff;

  logic [ACC_W-1:0]   ref_r, ref_nxt;
  logic [VALUE_W-1:0] tgt_r, tgt_nxt;
  logic [ACC_W-1:0]   steps_r, steps_nxt;
  logic [ACC_W-1:0]   amt_r, amt_nxt;
  logic [ACC_W-1:0]   step_r, step_nxt;
  logic [ACC_W+1:0]   diff_r, diff_nxt;
  logic [ACC_W-1:0]   mag_r, mag_nxt;
  logic               pos_r, pos_nxt;
  logic               neg_r, neg_nxt;

  // shared divider
  logic [ACC_W-1:0]     rem_r, rem_nxt;
  logic [DIV_W-1:0]     quo_r, quo_nxt;
  logic [ACC_W-1:0]     dvs_r, dvs_nxt;
  logic [DIV_CNT_W-1:0] dcnt_r, dcnt_nxt;
  logic                 div_ld;
  logic [DIV_W-1:0]     div_ld_quo;
  logic [ACC_W-1:0]     div_ld_dvs;
  logic [DIV_CNT_W-1:0] div_ld_cnt;
  logic [ACC_W:0]       div_shift;
  logic [ACC_W+1:0]     div_trial;
  logic                 div_done;

  // shared multiplier
  logic signed [ACC_W:0]         mul_a;
  logic signed [REG_W:0]         mul_b;
  logic signed [DIV_W+1:0]       mul_prod;

  logic                 out_valid_r, out_valid_nxt;
  logic [VALUE_W-1:0]   out_val_r;
  logic                 out_done_r;
  logic                 out_load;
  logic [VALUE_W-1:0]   out_val;

  logic               in_acc;
  logic [ACC_W-1:0]   ref_abs;
  logic [ACC_W+1:0]   tgt_ext;
  logic [ACC_W+1:0]   diff_neg;
  logic [ACC_W-1:0]   cnt_sat;
  logic [ACC_W:0]     tgt_mul;

  assign scale_eff = (scale_r == '0) ? REG_W'(1) : scale_r;
  assign freq_eff  = (freq_r == '0) ? REG_W'(1) : freq_r;

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;

  assign ref_abs  = ref_r[ACC_W-1] ? (ACC_W'(0) - ref_r) : ref_r;
  assign tgt_ext  = {{(ACC_W+2-VALUE_W){tgt_r[VALUE_W-1]}}, tgt_r};
  assign tgt_mul  = {{(ACC_W+1-VALUE_W){tgt_r[VALUE_W-1]}}, tgt_r};
  assign diff_neg = (ACC_W+2)'(0) - diff_r;
  assign cnt_sat  = ((quo_r[DIV_W-1:ACC_W] != '0) || (&quo_r[ACC_W-1:0])) ?
                    '1 : (quo_r[ACC_W-1:0] + ACC_W'(1));
  assign out_val  = neg_r ? (VALUE_W'(0) - quo_r[VALUE_W-1:0]) : quo_r[VALUE_W-1:0];

  assign mul_b    = $signed({1'b0, scale_eff});
  assign mul_prod = mul_a * mul_b;

  // Restoring divider: one quotient bit per cycle, dividend shifts in from the top.
  assign div_shift = {rem_r, quo_r[DIV_W-1]};
  assign div_trial = {1'b0, div_shift} - {2'b00, dvs_r};
  assign div_done  = (dcnt_r == '0);

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    dcnt_nxt = dcnt_r;
    if (div_ld) begin
      rem_nxt  = '0;
      quo_nxt  = div_ld_quo;
      dvs_nxt  = div_ld_dvs;
      dcnt_nxt = div_ld_cnt;
    end else if (!div_done) begin
      rem_nxt  = div_trial[ACC_W+1] ? div_shift[ACC_W-1:0] : div_trial[ACC_W-1:0];
      quo_nxt  = {quo_r[DIV_W-2:0], !div_trial[ACC_W+1]};
      dcnt_nxt = dcnt_r - DIV_CNT_W'(1);
    end
  end

  always_comb begin
    state_nxt  = state_r;
    ref_nxt    = ref_r;
    tgt_nxt    = tgt_r;
    steps_nxt  = steps_r;
    amt_nxt    = amt_r;
    step_nxt   = step_r;
    diff_nxt   = diff_r;
    mag_nxt    = mag_r;
    pos_nxt    = pos_r;
    neg_nxt    = neg_r;
    mul_a      = '0;
    div_ld     = 1'b0;
    div_ld_quo = '0;
    div_ld_dvs = '0;
    div_ld_cnt = DIV_SHORT;
    out_load   = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = S_OUT_LD;
          case (cmd_t'(in_command))
            CMD_TICK: begin
              mul_a = tgt_mul;
              if (steps_r > ACC_W'(1)) begin
                ref_nxt   = ref_r + amt_r;
                steps_nxt = steps_r - ACC_W'(1);
              end else if (steps_r == ACC_W'(1)) begin
                // last tick: land exactly on the target
                ref_nxt   = mul_prod[ACC_W-1:0];
                steps_nxt = '0;
              end
            end
            CMD_START: begin
              mul_a      = $signed({{(ACC_W+1-16){1'b0}}, in_slope_per_second});
              tgt_nxt    = in_target_value;
              div_ld     = 1'b1;
              div_ld_quo = {mul_prod[ACC_W-1:0], {(DIV_W-ACC_W){1'b0}}};
              div_ld_dvs = {{(ACC_W-REG_W){1'b0}}, freq_eff};
              div_ld_cnt = DIV_SHORT;
              state_nxt  = S_STEP_DIV;
            end
            CMD_STOP: begin
              steps_nxt = '0;
              amt_nxt   = '0;
            end
            default: begin
              // unused command: report only
            end
          endcase
        end
      end
      S_STEP_DIV: begin
        if (div_done) begin
          step_nxt = quo_r[ACC_W-1:0];
          if (quo_r[ACC_W-1:0] == '0) begin
            // zero step: jump to the target
            mul_a     = tgt_mul;
            ref_nxt   = mul_prod[ACC_W-1:0];
            steps_nxt = '0;
            amt_nxt   = '0;
            state_nxt = S_OUT_LD;
          end else begin
            div_ld     = 1'b1;
            div_ld_quo = {ref_abs, {(DIV_W-ACC_W){1'b0}}};
            div_ld_dvs = {{(ACC_W-REG_W){1'b0}}, scale_eff};
            div_ld_cnt = DIV_SHORT;
            neg_nxt    = ref_r[ACC_W-1];
            state_nxt  = S_CUR_DIV;
          end
        end
      end
      S_CUR_DIV: begin
        if (div_done) begin
          // target minus signed current value, sign folded into add or subtract
          diff_nxt  = neg_r ? (tgt_ext + {2'b00, quo_r[ACC_W-1:0]}) :
                              (tgt_ext - {2'b00, quo_r[ACC_W-1:0]});
          state_nxt = S_DIFF;
        end
      end
      S_DIFF: begin
        mag_nxt   = diff_r[ACC_W+1] ? diff_neg[ACC_W-1:0] : diff_r[ACC_W-1:0];
        pos_nxt   = !diff_r[ACC_W+1] && (diff_r != '0);
        state_nxt = S_CNT_MUL;
      end
      S_CNT_MUL: begin
        mul_a      = $signed({1'b0, mag_r});
        div_ld     = 1'b1;
        div_ld_quo = mul_prod[DIV_W-1:0];
        div_ld_dvs = step_r;
        div_ld_cnt = DIV_LONG;
        state_nxt  = S_CNT_DIV;
      end
      S_CNT_DIV: begin
        if (div_done) begin
          steps_nxt = cnt_sat;
          amt_nxt   = pos_r ? step_r : (ACC_W'(0) - step_r);
          state_nxt = S_OUT_LD;
        end
      end
      S_OUT_LD: begin
        div_ld     = 1'b1;
        div_ld_quo = {ref_abs, {(DIV_W-ACC_W){1'b0}}};
        div_ld_dvs = {{(ACC_W-REG_W){1'b0}}, scale_eff};
        div_ld_cnt = DIV_SHORT;
        neg_nxt    = ref_r[ACC_W-1];
        state_nxt  = S_OUT_DIV;
      end
      S_OUT_DIV: begin
        // hold the result until the output register is free
        if (div_done && (!out_valid_r || !out_stall)) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid_nxt = out_load ? 1'b1 : (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      scale_r     <= SCALE_RST;
      freq_r      <= FREQ_RST;
      ref_r       <= '0;
      tgt_r       <= '0;
      steps_r     <= '0;
      amt_r       <= '0;
      dcnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ref_r       <= ref_nxt;
      tgt_r       <= tgt_nxt;
      steps_r     <= steps_nxt;
      amt_r       <= amt_nxt;
      dcnt_r      <= dcnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_write_en) begin
        case (cfg_index)
          CFG_SCALE: scale_r <= cfg_wdata;
          CFG_FREQ:  freq_r  <= cfg_wdata;
          default: begin
            // no register at this index
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    step_r <= step_nxt;
    diff_r <= diff_nxt;
    mag_r  <= mag_nxt;
    pos_r  <= pos_nxt;
    neg_r  <= neg_nxt;
    rem_r  <= rem_nxt;
    quo_r  <= quo_nxt;
    dvs_r  <= dvs_nxt;
    if (out_load) begin
      out_val_r  <= out_val;
      out_done_r <= (steps_r == '0);
    end
  end

  assign out_valid         = out_valid_r;
  assign out_current_value = out_val_r;
  assign out_ramp_done     = out_done_r;

  `LRG_ASSERT_NEVER(a_div_idle, (dcnt_r != '0) && (state_r != S_STEP_DIV) && (state_r != S_CUR_DIV) && (state_r != S_CNT_DIV) && (state_r != S_OUT_DIV), "divider running outside a divide state")
  `LRG_ASSERT_NEVER(a_steps_amt, (steps_r != '0) && (amt_r == '0), "steps remain with zero step amount")
  `LRG_ASSERT(a_jump_clear, (state_r == S_STEP_DIV) && div_done && (quo_r[ACC_W-1:0] == '0) |=> (steps_r == '0) && (amt_r == '0) && (state_r == S_OUT_LD), "zero step did not jump")
  `LRG_ASSERT(a_done_flag, out_load |=> out_valid_r && (out_done_r == (steps_r == '0)), "done flag disagrees with remaining steps")

endmodule
